// ===== hw/rtl/vdt_pkg.sv =====
// ----------------------------------------------------------------------------
// vdt_pkg
// Shared constants, types and controller/datapath links for the vertex
// deduplication index table.
// ----------------------------------------------------------------------------
package vdt_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int COORD_BITS  = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int DIFF_W      = COORD_BITS + 1;
	localparam int TOL_W       = 8;
	localparam int INDEX_OUT_W = 8;
	localparam int ENTRY_W     = 3 * COORD_BITS;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [APB_ADDR_W-1:0] REG_TOL_ADDR = APB_ADDR_W'(0);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_done;
	} ctrl_status_t;

endpackage

// ===== hw/rtl/vdt_in_if.sv =====
// ----------------------------------------------------------------------------
// vdt_in_if
// Vertex request channel: one corner of a face per request.
// ----------------------------------------------------------------------------
interface vdt_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [vdt_pkg::COORD_BITS-1:0] coord_x;
	logic signed [vdt_pkg::COORD_BITS-1:0] coord_y;
	logic signed [vdt_pkg::COORD_BITS-1:0] coord_z;
	logic                                  last_of_face;

	modport source (output valid, coord_x, coord_y, coord_z, last_of_face, input ready);
	modport sink   (input valid, coord_x, coord_y, coord_z, last_of_face, output ready);
endinterface

// ===== hw/rtl/vdt_out_if.sv =====
// ----------------------------------------------------------------------------
// vdt_out_if
// Index result channel: one result per vertex request.
// ----------------------------------------------------------------------------
interface vdt_out_if;
	logic                               valid;
	logic                               ready;
	logic [vdt_pkg::INDEX_OUT_W-1:0]    vertex_index;
	logic                               was_new;
	logic                               table_overflow;
	logic                               face_end;

	modport source (output valid, vertex_index, was_new, table_overflow, face_end,
		input ready);
	modport sink   (input valid, vertex_index, was_new, table_overflow, face_end,
		output ready);
endinterface

// ===== hw/rtl/vertex_dedup_index_table.sv =====
// ----------------------------------------------------------------------------
// vertex_dedup_index_table
// Looks up each incoming vertex in a vertex table within a per-axis
// tolerance; returns the first matching index, else appends or flags overflow.
// ----------------------------------------------------------------------------
// Scan: stops at the first matching entry, or reads every stored entry on a
//   miss; a new request is taken once the previous result is loaded into
//   the output register. The scan reads one table entry per cycle, so the
//   request rate falls with the entry count.
// Reset: clears the entry count and match_tolerance; table contents are
//   undefined until written, and a result may sit in the output register
//   while the next request is taken.
module vertex_dedup_index_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [vdt_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [vdt_pkg::APB_DATA_W-1:0] pwdata,
	output logic [vdt_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	vdt_in_if.sink                         vtx_in,
	vdt_out_if.source                      idx_out
);
	import vdt_pkg::*;

	logic [TOL_W-1:0] tol_q;
	logic             reg_wr;
	ctrl_cmd_t        cmd;
	ctrl_status_t     status;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready && (paddr == REG_TOL_ADDR);
	assign prdata = (paddr == REG_TOL_ADDR) ? APB_DATA_W'(tol_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (reg_wr) begin
			tol_q <= pwdata[TOL_W-1:0];
		end
	end

	vdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vtx_in.valid),
		.in_ready  (vtx_in.ready),
		.out_valid (idx_out.valid),
		.out_ready (idx_out.ready),
		.cmd       (cmd),
		.status    (status)
	);

	vdt_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.tol            (tol_q),
		.coord_x        (vtx_in.coord_x),
		.coord_y        (vtx_in.coord_y),
		.coord_z        (vtx_in.coord_z),
		.last_of_face   (vtx_in.last_of_face),
		.vertex_index   (idx_out.vertex_index),
		.was_new        (idx_out.was_new),
		.table_overflow (idx_out.table_overflow),
		.face_end       (idx_out.face_end)
	);

endmodule

// ===== hw/rtl/vdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// vdt_ctrl
// Sequencer: accepts a vertex, runs the table scan, and hands the result to
// the output register once it is free.
// ----------------------------------------------------------------------------
module vdt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output vdt_pkg::ctrl_cmd_t    cmd,
	input  vdt_pkg::ctrl_status_t status
);
	import vdt_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.scan_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		cmd.start = 1'b0;
		cmd.scan  = 1'b0;
		cmd.load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_DONE: begin
				cmd.load = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");

	a_start_enters_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == ST_SCAN))
		else $error("accepted request did not start a scan");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result shown without a finished scan");

endmodule

// ===== hw/rtl/vdt_datapath.sv =====
// ----------------------------------------------------------------------------
// vdt_datapath
// Vertex memory, entry count, scan pipeline with tolerance compare, and the
// output payload register.
// ----------------------------------------------------------------------------
module vdt_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  vdt_pkg::ctrl_cmd_t                    cmd,
	output vdt_pkg::ctrl_status_t                 status,
	input  logic [vdt_pkg::TOL_W-1:0]             tol,
	input  logic signed [vdt_pkg::COORD_BITS-1:0] coord_x,
	input  logic signed [vdt_pkg::COORD_BITS-1:0] coord_y,
	input  logic signed [vdt_pkg::COORD_BITS-1:0] coord_z,
	input  logic                                  last_of_face,
	output logic [vdt_pkg::INDEX_OUT_W-1:0]       vertex_index,
	output logic                                  was_new,
	output logic                                  table_overflow,
	output logic                                  face_end
);
	import vdt_pkg::*;

	logic [ENTRY_W-1:0] mem_q [TABLE_DEPTH];

	logic [COORD_BITS-1:0] x_q;
	logic [COORD_BITS-1:0] y_q;
	logic [COORD_BITS-1:0] z_q;
	logic                  fend_q;

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   issue_addr_q;
	logic               issue_en;
	logic               rd_vld_s1;
	logic [ENTRY_W-1:0] rd_data_s1;
	logic [IDX_W-1:0]   rd_idx_s1;

	logic               hit;
	logic               near_x;
	logic               near_y;
	logic               near_z;
	logic               found_q;
	logic [IDX_W-1:0]   found_idx_q;
	logic               full;
	logic               append;
	logic [IDX_W-1:0]   sel_idx;
	logic [IDX_W+INDEX_OUT_W-1:0] sel_idx_ext;

	logic [INDEX_OUT_W-1:0] res_idx_q;
	logic                   res_new_q;
	logic                   res_ovf_q;
	logic                   res_fend_q;

	function automatic logic near_axis(input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b, input logic [TOL_W-1:0] t);
		logic signed [DIFF_W-1:0] d;
		logic [DIFF_W-1:0]        mag;
		d   = signed'({a[COORD_BITS-1], a}) - signed'({b[COORD_BITS-1], b});
		mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
		return mag <= {{(DIFF_W-TOL_W){1'b0}}, t};
	endfunction

	assign near_x = near_axis(x_q, rd_data_s1[3*COORD_BITS-1:2*COORD_BITS], tol);
	assign near_y = near_axis(y_q, rd_data_s1[2*COORD_BITS-1:COORD_BITS], tol);
	assign near_z = near_axis(z_q, rd_data_s1[COORD_BITS-1:0], tol);
	assign hit    = rd_vld_s1 && near_x && near_y && near_z;

	assign issue_en = cmd.scan && !hit && (issue_addr_q < count_q);
	assign status.scan_done = cmd.scan && (hit || (!rd_vld_s1 && (issue_addr_q >= count_q)));

	assign full   = (count_q == CNT_W'(TABLE_DEPTH));
	assign append = cmd.load && !found_q && !full;

	always_comb begin
		if (found_q) begin
			sel_idx = found_idx_q;
		end else if (full) begin
			sel_idx = '0;
		end else begin
			sel_idx = count_q[IDX_W-1:0];
		end
	end

	assign sel_idx_ext = {{INDEX_OUT_W{1'b0}}, sel_idx};

	always_ff @(posedge clk) begin
		if (append) begin
			mem_q[count_q[IDX_W-1:0]] <= {x_q, y_q, z_q};
		end
		if (issue_en) begin
			rd_data_s1 <= mem_q[issue_addr_q[IDX_W-1:0]];
			rd_idx_s1  <= issue_addr_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q    <= coord_x;
			y_q    <= coord_y;
			z_q    <= coord_z;
			fend_q <= last_of_face;
		end
		if (status.scan_done) begin
			found_q     <= hit;
			found_idx_q <= rd_idx_s1;
		end
		if (cmd.load) begin
			res_idx_q  <= sel_idx_ext[INDEX_OUT_W-1:0];
			res_new_q  <= !found_q && !full;
			res_ovf_q  <= !found_q && full;
			res_fend_q <= fend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			issue_addr_q <= '0;
			rd_vld_s1    <= 1'b0;
		end else begin
			rd_vld_s1 <= issue_en;
			if (cmd.start) begin
				issue_addr_q <= '0;
			end else if (issue_en) begin
				issue_addr_q <= issue_addr_q + CNT_W'(1);
			end
			if (append) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	assign vertex_index   = res_idx_q;
	assign was_new        = res_new_q;
	assign table_overflow = res_ovf_q;
	assign face_end       = res_fend_q;

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_match_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && found_q) |-> (CNT_W'(found_idx_q) < count_q))
		else $error("matched index outside stored entries");

	a_append_advances: assert property (@(posedge clk) disable iff (!arst_n)
		append |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("append did not advance entry count");

endmodule

// ===== verif/vdt_index_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vdt_index_check
// Watches the vertex and index channels and the register port of the vertex
// deduplication index table. Keeps its own copy of the vertex table and the
// tolerance, works out the index each vertex request should get, and compares
// every result field against the oldest pending lookup.
// ----------------------------------------------------------------------------
module vdt_index_check (
	input  logic                           clk,
	input  logic                           arst_n,
	vdt_in_if                              vin,
	vdt_out_if                             vout,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [vdt_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [vdt_pkg::APB_DATA_W-1:0] pwdata,
	input  logic [vdt_pkg::APB_DATA_W-1:0] prdata,
	input  logic                           pready,
	output int                             errors,
	output int                             outstanding,
	output int                             hits,
	output int                             appends,
	output int                             overflows
);
	import vdt_pkg::*;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic [INDEX_OUT_W-1:0] vertex_index;
		logic                   was_new;
		logic                   table_overflow;
		logic                   face_end;
	} idx_result_t;

	coord_t           tbl_x [TABLE_DEPTH];
	coord_t           tbl_y [TABLE_DEPTH];
	coord_t           tbl_z [TABLE_DEPTH];
	int               stored;
	logic [TOL_W-1:0] tolerance;
	idx_result_t      pending_idx_q [$];
	idx_result_t      want;
	idx_result_t      predicted;

	initial begin
		errors = 0;
		outstanding = 0;
	end

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		if (errors < 50)
			$display("%0t: %s: got %0d, want %0d", $realtime, what, got, exp_val);
		errors++;
	endtask

	function automatic bit axis_near(coord_t a, coord_t b, int tl);
		int d;
		d = int'(a) - int'(b);
		if (d < 0)
			d = -d;
		return d <= tl;
	endfunction

	function automatic idx_result_t lookup_vertex(coord_t x, coord_t y, coord_t z, logic fe);
		idx_result_t r;
		int          tl;
		int          k;
		bit          hit;
		r = '0;
		r.face_end = fe;
		tl = int'(tolerance);
		hit = 1'b0;
		for (k = 0; k < stored && !hit; k++) begin
			if (axis_near(x, tbl_x[k], tl) && axis_near(y, tbl_y[k], tl) &&
					axis_near(z, tbl_z[k], tl)) begin
				hit = 1'b1;
				r.vertex_index = INDEX_OUT_W'(k);
			end
		end
		if (!hit) begin
			if (stored < TABLE_DEPTH) begin
				tbl_x[stored] = x;
				tbl_y[stored] = y;
				tbl_z[stored] = z;
				r.vertex_index = INDEX_OUT_W'(stored);
				r.was_new = 1'b1;
				stored++;
			end else begin
				r.table_overflow = 1'b1;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored = 0;
			tolerance = '0;
			pending_idx_q.delete();
			hits = 0;
			appends = 0;
			overflows = 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pready && paddr == REG_TOL_ADDR) begin
				if (pwrite)
					tolerance = pwdata[TOL_W-1:0];
				else if (prdata[TOL_W-1:0] !== tolerance)
					report_mismatch("match_tolerance readback", int'(prdata[TOL_W-1:0]),
						int'(tolerance));
			end
			if (vout.valid && vout.ready) begin
				if (pending_idx_q.size() == 0) begin
					report_mismatch("result with no request pending", int'(vout.vertex_index), -1);
				end else begin
					want = pending_idx_q.pop_front();
					if (vout.vertex_index !== want.vertex_index)
						report_mismatch("vertex_index", int'(vout.vertex_index),
							int'(want.vertex_index));
					if (vout.was_new !== want.was_new)
						report_mismatch("was_new", int'(vout.was_new), int'(want.was_new));
					if (vout.table_overflow !== want.table_overflow)
						report_mismatch("table_overflow", int'(vout.table_overflow),
							int'(want.table_overflow));
					if (vout.face_end !== want.face_end)
						report_mismatch("face_end", int'(vout.face_end), int'(want.face_end));
					if (want.table_overflow)
						overflows++;
					else if (want.was_new)
						appends++;
					else
						hits++;
				end
			end
			if (vin.valid && vin.ready) begin
				predicted = lookup_vertex(vin.coord_x, vin.coord_y, vin.coord_z,
					vin.last_of_face);
				pending_idx_q.insert(pending_idx_q.size(), predicted);
			end
			outstanding <= pending_idx_q.size();
		end
	end

endmodule

// ===== verif/tb_vertex_dedup_index_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vertex_dedup_index_table
// Drives vertex requests and tolerance writes into the vertex deduplication
// index table: a directed opening on coordinate extremes and tolerance edges,
// then face-shaped random streams that fill the table past capacity, with
// random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_vertex_dedup_index_table;
	import vdt_pkg::*;

	localparam int LIMIT        = 2000000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 300;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
	} vtx_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int   errors;
	int   outstanding;
	int   hits;
	int   appends;
	int   overflows;
	int   cycles = 0;
	int   n_sent = 0;
	int   rx_stall = 0;
	logic quiet = 1'b0;
	logic hold_go = 1'b0;
	logic hold_on = 1'b0;
	vtx_t sent_q [$];

	vdt_in_if  vtx_ch ();
	vdt_out_if idx_ch ();

	vertex_dedup_index_table u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.vtx_in  (vtx_ch),
		.idx_out (idx_ch)
	);

	vdt_index_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.vin         (vtx_ch),
		.vout        (idx_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.errors      (errors),
		.outstanding (outstanding),
		.hits        (hits),
		.appends     (appends),
		.overflows   (overflows)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_on) begin
			idx_ch.ready <= 1'b0;
		end else if (rx_stall != 0) begin
			idx_ch.ready <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			idx_ch.ready <= 1'b0;
			rx_stall <= $urandom_range(0, 6);
		end else begin
			idx_ch.ready <= 1'b1;
		end
	end

	initial begin
		do @(posedge clk); while (!hold_go);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	function automatic vtx_t mk_vtx(int x, int y, int z);
		vtx_t v;
		v.x = coord_t'(x);
		v.y = coord_t'(y);
		v.z = coord_t'(z);
		return v;
	endfunction

	function automatic coord_t nudge(coord_t c, int span);
		int v;
		v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return coord_t'(v);
	endfunction

	task automatic apb_access(logic wr, logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= REG_TOL_ADDR;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_tolerance(logic [TOL_W-1:0] tol);
		logic [APB_DATA_W-1:0] data;
		vtx_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		data = $urandom;
		data[TOL_W-1:0] = tol;
		apb_access(1'b1, data);
		@(posedge clk);
		apb_access(1'b0, '0);
	endtask

	task automatic send_vertex(vtx_t v, logic last, bit calm);
		int gap;
		if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 7);
			vtx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vtx_ch.valid <= 1'b1;
		vtx_ch.coord_x <= v.x;
		vtx_ch.coord_y <= v.y;
		vtx_ch.coord_z <= v.z;
		vtx_ch.last_of_face <= last;
		do @(posedge clk); while (!vtx_ch.ready);
		sent_q.insert(sent_q.size(), v);
		n_sent++;
	endtask

	task automatic send_face(int fresh_pct, int span);
		int   corners;
		int   k;
		int   pick;
		int   recent;
		bit   calm;
		logic last;
		vtx_t v;
		corners = $urandom_range(3, 4);
		calm = ($urandom_range(0, 4) == 0);
		for (k = 0; k < corners; k++) begin
			if (sent_q.size() == 0 || $urandom_range(0, 99) < fresh_pct) begin
				v.x = coord_t'($urandom);
				v.y = coord_t'($urandom);
				v.z = coord_t'($urandom);
			end else begin
				recent = (sent_q.size() < 12) ? sent_q.size() : 12;
				if ($urandom_range(0, 1) == 0)
					pick = sent_q.size() - 1 - $urandom_range(0, recent - 1);
				else
					pick = $urandom_range(0, sent_q.size() - 1);
				v = sent_q[pick];
				v.x = nudge(v.x, span);
				v.y = nudge(v.y, span);
				v.z = nudge(v.z, span);
			end
			last = (k == corners - 1);
			if ($urandom_range(0, 9) == 0)
				last = 1'($urandom_range(0, 1));
			send_vertex(v, last, calm);
		end
	endtask

	task automatic run_faces(int target, int fresh_pct, int span);
		while (n_sent < target)
			send_face(fresh_pct, span);
	endtask

	initial begin
		int tol;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		vtx_ch.valid = 1'b0;
		vtx_ch.coord_x = '0;
		vtx_ch.coord_y = '0;
		vtx_ch.coord_z = '0;
		vtx_ch.last_of_face = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_tolerance(8'd0);
		send_vertex(mk_vtx(-32768, -32768, -32768), 1'b0, 1'b1);
		send_vertex(mk_vtx(32767, 32767, 32767), 1'b0, 1'b1);
		send_vertex(mk_vtx(0, 0, 0), 1'b1, 1'b1);
		send_vertex(mk_vtx(-32768, -32768, -32768), 1'b0, 1'b1);
		send_vertex(mk_vtx(32767, 32767, 32766), 1'b0, 1'b1);
		send_vertex(mk_vtx(0, 0, 0), 1'b1, 1'b1);
		send_vertex(mk_vtx(-1, -1, -1), 1'b0, 1'b1);
		send_vertex(mk_vtx(21845, -21846, 21845), 1'b0, 1'b1);
		send_vertex(mk_vtx(-21846, 21845, -21846), 1'b1, 1'b1);
		send_vertex(mk_vtx(-1, -1, -1), 1'b1, 1'b1);

		set_tolerance(8'd255);
		send_vertex(mk_vtx(32512, 32767, 32512), 1'b0, 1'b1);
		send_vertex(mk_vtx(-32512, -32768, -32768), 1'b0, 1'b1);
		send_vertex(mk_vtx(255, -255, 0), 1'b1, 1'b1);
		send_vertex(mk_vtx(32767, -32768, 0), 1'b0, 1'b1);
		send_vertex(mk_vtx(-32768, 32767, 32767), 1'b0, 1'b1);
		send_vertex(mk_vtx(256, 0, 0), 1'b0, 1'b1);
		send_vertex(mk_vtx(0, 0, -256), 1'b1, 1'b1);
		send_vertex(mk_vtx(-32257, -32768, -32513), 1'b1, 1'b1);

		tol = $urandom_range(1, 12);
		set_tolerance(TOL_W'(tol));
		run_faces(560, 55, tol + 1);

		set_tolerance(8'd255);
		hold_go <= 1'b1;
		run_faces(900, 35, 260);

		tol = $urandom_range(1, 254);
		set_tolerance(TOL_W'(tol));
		run_faces(1250, 25, tol + 1);

		set_tolerance(8'd0);
		quiet <= 1'b1;
		run_faces(1400, 20, 1);

		vtx_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d vertex requests over tolerances 0, 255 and two random values.",
			n_sent);
		$display("Results: %0d matched, %0d appended, %0d refused on a full table.",
			hits, appends, overflows);
		if (errors == 0 && outstanding == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
